### hw/rtl/dlbd_pkg.sv
// Package: constants, controller states and command word for the dual lane byte digest
`timescale 1ns / 1ps

package dlbd_pkg;

    localparam logic [63:0] FNV_START = 64'hCBF29CE484222325;
    localparam logic [63:0] ROT_START = 64'h6A09E667F3BCC909;
    localparam logic [63:0] GOLDEN    = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B = 64'h94D049BB133111EB;

    localparam int FNV_PRIME_SHIFT = 40;
    localparam logic [8:0] FNV_PRIME_LOW = 9'h1B3;

    localparam int ROT_AMOUNT  = 7;
    localparam int SHIFT_LOAD  = 30;
    localparam int SHIFT_MID   = 27;
    localparam int SHIFT_FINAL = 31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL_LO,
        ST_MUL_HL,
        ST_MUL_LH,
        ST_MIX
    } state_t;

    typedef struct packed {
        logic absorb;
        logic load;
        logic lane_lo;
        logic mul_lo;
        logic mul_hl;
        logic mul_lh;
        logic mul_b;
        logic mix;
        logic store;
    } cmd_t;

endpackage

### hw/rtl/dlbd_ctrl.sv
// Controller: sequences absorb, lane load, split multiplies, mixing and output hand-off
`timescale 1ns / 1ps

module dlbd_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          byte_present,
    input  logic          last,
    input  logic          out_ready,
    output logic          in_ready,
    output logic          out_valid,
    output dlbd_pkg::cmd_t cmd
);

    dlbd_pkg::state_t state_reg;
    dlbd_pkg::state_t state_next;
    logic             mul_b_reg;
    logic             mul_b_next;
    logic             lane_lo_reg;
    logic             lane_lo_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;
    logic             final_mix;
    logic             slot_free;

    assign accept    = in_valid && (state_reg == dlbd_pkg::ST_IDLE);
    assign final_mix = (state_reg == dlbd_pkg::ST_MIX) && mul_b_reg && lane_lo_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dlbd_pkg::ST_IDLE;
            mul_b_reg     <= 1'b0;
            lane_lo_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mul_b_reg     <= mul_b_next;
            lane_lo_reg   <= lane_lo_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mul_b_next     = mul_b_reg;
        lane_lo_next   = lane_lo_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            dlbd_pkg::ST_IDLE:
            begin
                if (accept && last)
                begin
                    state_next   = dlbd_pkg::ST_LOAD;
                    mul_b_next   = 1'b0;
                    lane_lo_next = 1'b0;
                end
            end
            dlbd_pkg::ST_LOAD:
            begin
                state_next = dlbd_pkg::ST_MUL_LO;
            end
            dlbd_pkg::ST_MUL_LO:
            begin
                state_next = dlbd_pkg::ST_MUL_HL;
            end
            dlbd_pkg::ST_MUL_HL:
            begin
                state_next = dlbd_pkg::ST_MUL_LH;
            end
            dlbd_pkg::ST_MUL_LH:
            begin
                state_next = dlbd_pkg::ST_MIX;
            end
            dlbd_pkg::ST_MIX:
            begin
                if (!mul_b_reg)
                begin
                    mul_b_next = 1'b1;
                    state_next = dlbd_pkg::ST_MUL_LO;
                end
                else if (!lane_lo_reg)
                begin
                    mul_b_next   = 1'b0;
                    lane_lo_next = 1'b1;
                    state_next   = dlbd_pkg::ST_LOAD;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = dlbd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dlbd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = (state_reg == dlbd_pkg::ST_IDLE);
        out_valid    = out_valid_reg;
        cmd.absorb   = accept && byte_present;
        cmd.load     = (state_reg == dlbd_pkg::ST_LOAD);
        cmd.lane_lo  = lane_lo_reg;
        cmd.mul_lo   = (state_reg == dlbd_pkg::ST_MUL_LO);
        cmd.mul_hl   = (state_reg == dlbd_pkg::ST_MUL_HL);
        cmd.mul_lh   = (state_reg == dlbd_pkg::ST_MUL_LH);
        cmd.mul_b    = mul_b_reg;
        cmd.mix      = (state_reg == dlbd_pkg::ST_MIX) && !(final_mix && !slot_free);
        cmd.store    = final_mix && slot_free;
    end

endmodule

### hw/rtl/dlbd_datapath.sv
// Datapath: lane registers, byte count, shared 32x32 multiplier and digest registers
`timescale 1ns / 1ps

module dlbd_datapath
(
    input  logic           clk,
    input  logic           rst_n,
    input  dlbd_pkg::cmd_t cmd,
    input  logic [7:0]     data_byte,
    output logic [63:0]    digest_hi,
    output logic [63:0]    digest_lo
);

    logic [63:0] fnv_reg;
    logic [63:0] fnv_next;
    logic [63:0] rot_reg;
    logic [63:0] rot_next;
    logic [63:0] cnt_reg;
    logic [63:0] cnt_next;
    logic [63:0] x_reg;
    logic [63:0] x_next;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [63:0] hold_reg;
    logic [63:0] hold_next;
    logic [63:0] dig_hi_reg;
    logic [63:0] dig_hi_next;
    logic [63:0] dig_lo_reg;
    logic [63:0] dig_lo_next;

    logic [63:0] fnv_mixed;
    logic [63:0] rot_left;
    logic [63:0] byte_term;
    logic [63:0] fold;
    logic [63:0] seed;
    logic [63:0] mix_const;
    logic [31:0] mul_x;
    logic [31:0] mul_c;
    logic [63:0] product;
    logic [63:0] mixed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fnv_reg <= dlbd_pkg::FNV_START;
            rot_reg <= dlbd_pkg::ROT_START;
            cnt_reg <= 64'd0;
        end
        else
        begin
            fnv_reg <= fnv_next;
            rot_reg <= rot_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        acc_reg    <= acc_next;
        hold_reg   <= hold_next;
        dig_hi_reg <= dig_hi_next;
        dig_lo_reg <= dig_lo_next;
    end

    always_comb
    begin
        fnv_mixed = fnv_reg ^ {56'd0, data_byte};
        rot_left  = {rot_reg[63-dlbd_pkg::ROT_AMOUNT:0],
                     rot_reg[63:64-dlbd_pkg::ROT_AMOUNT]};
        byte_term = 64'({56'd0, data_byte} * dlbd_pkg::GOLDEN) + dlbd_pkg::MIX_MUL_A;

        if (cmd.lane_lo)
        begin
            fold = fnv_reg ^ ((cnt_reg << dlbd_pkg::FNV_PRIME_SHIFT)
                              + 64'(cnt_reg * {55'd0, dlbd_pkg::FNV_PRIME_LOW}));
        end
        else
        begin
            fold = rot_reg ^ (cnt_reg + dlbd_pkg::GOLDEN);
        end
        seed = fold + dlbd_pkg::GOLDEN;

        mix_const = cmd.mul_b ? dlbd_pkg::MIX_MUL_B : dlbd_pkg::MIX_MUL_A;
        mul_x     = cmd.mul_hl ? x_reg[63:32] : x_reg[31:0];
        mul_c     = cmd.mul_lh ? mix_const[63:32] : mix_const[31:0];
        product   = {32'd0, mul_x} * {32'd0, mul_c};

        if (cmd.mul_b)
        begin
            mixed = x_reg ^ (x_reg >> dlbd_pkg::SHIFT_FINAL);
        end
        else
        begin
            mixed = x_reg ^ (x_reg >> dlbd_pkg::SHIFT_MID);
        end
    end

    always_comb
    begin
        fnv_next    = fnv_reg;
        rot_next    = rot_reg;
        cnt_next    = cnt_reg;
        x_next      = x_reg;
        acc_next    = acc_reg;
        hold_next   = hold_reg;
        dig_hi_next = dig_hi_reg;
        dig_lo_next = dig_lo_reg;

        if (cmd.absorb)
        begin
            fnv_next = (fnv_mixed << dlbd_pkg::FNV_PRIME_SHIFT)
                       + 64'(fnv_mixed * {55'd0, dlbd_pkg::FNV_PRIME_LOW});
            rot_next = (rot_left ^ byte_term) + dlbd_pkg::MIX_MUL_B;
            cnt_next = cnt_reg + 64'd1;
        end

        if (cmd.load)
        begin
            x_next = seed ^ (seed >> dlbd_pkg::SHIFT_LOAD);
            if (cmd.lane_lo)
            begin
                fnv_next = dlbd_pkg::FNV_START;
                rot_next = dlbd_pkg::ROT_START;
                cnt_next = 64'd0;
            end
        end

        if (cmd.mul_lo)
        begin
            acc_next = product;
        end
        if (cmd.mul_hl)
        begin
            acc_next = acc_reg + {product[31:0], 32'd0};
        end
        if (cmd.mul_lh)
        begin
            x_next = acc_reg + {product[31:0], 32'd0};
        end

        if (cmd.mix)
        begin
            if (!cmd.mul_b)
            begin
                x_next = mixed;
            end
            else if (!cmd.lane_lo)
            begin
                hold_next = mixed;
            end
        end

        if (cmd.store)
        begin
            dig_hi_next = hold_reg;
            dig_lo_next = mixed;
        end
    end

    assign digest_hi = dig_hi_reg;
    assign digest_lo = dig_lo_reg;

endmodule

### hw/rtl/dual_lane_byte_digest_128.sv
// Top level: 128-bit two-lane byte digest with valid/ready word channels
`timescale 1ns / 1ps

// Takes at most one message byte per input word (byte_present) and returns a 128-bit
// digest on the word marked last. A word that is not last is taken while ready stays high.
// A word marked last holds ready low while both lanes are finalised: each lane needs
// a load step and two 64-bit multiplies, each built from low, high-low and low-high
// partial products on the shared 32x32 multiplier and followed by a shift-xor step.
// The digest sits in an output register until taken; if it is still held when the
// next digest is ready, the finaliser waits. Both lanes and the byte count reload their
// start values when the second lane is loaded, so the next word starts a new message.

module dual_lane_byte_digest_128
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_hi,
    output logic [63:0] digest_lo
);

    dlbd_pkg::cmd_t cmd;

    dlbd_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .byte_present (byte_present),
        .last         (last),
        .out_ready    (out_ready),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .cmd          (cmd)
    );

    dlbd_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (data_byte),
        .digest_hi (digest_hi),
        .digest_lo (digest_lo)
    );

endmodule
